// ===== hdl/bst_pkg.sv =====
`default_nettype none

package bst_pkg;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned ProbeW = 3;
  localparam int unsigned StepW  = 4;

  typedef logic [StepW-1:0] step_t;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_CLEAR  = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    OP_NOP     = 3'd0,
    OP_LATCH   = 3'd1,
    OP_ZERO    = 3'd2,
    OP_APPEND  = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_INIT    = 3'd5,
    OP_PROBE   = 3'd6,
    OP_COMPARE = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    COND_NEXT      = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_NO_START  = 3'd2,
    COND_IS_APPEND = 3'd3,
    COND_IS_CLEAR  = 3'd4,
    COND_IS_SEARCH = 3'd5,
    COND_CROSSED   = 3'd6,
    COND_MISS      = 3'd7
  } cond_e;

  // OP_NOP in the done step still emits; emit is its own bit
  typedef struct packed {
    op_e   op;
    logic  emit_search;
    cond_e cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    logic is_append;
    logic is_clear;
    logic is_search;
    logic crossed;
    logic miss;
  } dp_stat_t;

  localparam step_t StepIdle    = 4'd0;
  localparam step_t StepZero    = 4'd4;
  localparam step_t StepAppend  = 4'd5;
  localparam step_t StepClear   = 4'd6;
  localparam step_t StepInit    = 4'd7;
  localparam step_t StepTest    = 4'd8;
  localparam step_t StepCompare = 4'd9;
  localparam step_t StepDone    = 4'd10;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '{op: OP_NOP, emit_search: 1'b0, cond: COND_ALWAYS, target: StepIdle};
    unique case (step)
      4'd0: w = '{op: OP_LATCH, emit_search: 1'b0, cond: COND_NO_START, target: StepIdle};
      4'd1: w = '{op: OP_NOP, emit_search: 1'b0, cond: COND_IS_APPEND, target: StepAppend};
      4'd2: w = '{op: OP_NOP, emit_search: 1'b0, cond: COND_IS_CLEAR, target: StepClear};
      4'd3: w = '{op: OP_NOP, emit_search: 1'b0, cond: COND_IS_SEARCH, target: StepInit};
      4'd4: w = '{op: OP_ZERO, emit_search: 1'b0, cond: COND_ALWAYS, target: StepIdle};
      4'd5: w = '{op: OP_APPEND, emit_search: 1'b0, cond: COND_ALWAYS, target: StepIdle};
      4'd6: w = '{op: OP_CLEAR, emit_search: 1'b0, cond: COND_ALWAYS, target: StepIdle};
      4'd7: w = '{op: OP_INIT, emit_search: 1'b0, cond: COND_NEXT, target: StepIdle};
      4'd8: w = '{op: OP_PROBE, emit_search: 1'b0, cond: COND_CROSSED, target: StepDone};
      4'd9: w = '{op: OP_COMPARE, emit_search: 1'b0, cond: COND_MISS, target: StepTest};
      4'd10: w = '{op: OP_NOP, emit_search: 1'b1, cond: COND_ALWAYS, target: StepIdle};
      default: w = '{op: OP_NOP, emit_search: 1'b0, cond: COND_ALWAYS, target: StepIdle};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/bst_seq.sv =====
`default_nettype none

module bst_seq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire bst_pkg::dp_stat_t stat_i,
  output bst_pkg::ucode_t       ucode_o,
  output logic                  busy_o
);
  import bst_pkg::*;

  step_t  step_q, step_d;
  ucode_t uc;
  logic   take;

  assign uc = ucode_rom(step_q);

  always_comb begin
    unique case (uc.cond)
      COND_NEXT:      take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_START:  take = !start;
      COND_IS_APPEND: take = stat_i.is_append;
      COND_IS_CLEAR:  take = stat_i.is_clear;
      COND_IS_SEARCH: take = stat_i.is_search;
      COND_CROSSED:   take = stat_i.crossed;
      COND_MISS:      take = stat_i.miss;
      default:        take = 1'b1;
    endcase
    step_d = take ? uc.target : step_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StepIdle;
    end else begin
      step_q <= step_d;
    end
  end

  assign ucode_o = uc;
  assign busy_o  = (step_q != StepIdle);

endmodule

`default_nettype wire

// ===== hdl/bst_dp.sv =====
`default_nettype none

module bst_dp #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  input  wire bst_pkg::ucode_t                ucode_i,
  input  wire logic [1:0]                     func_i,
  input  wire logic signed [bst_pkg::KeyW-1:0] key_value_i,
  output bst_pkg::dp_stat_t                   stat_o,
  output logic                                result_valid_o,
  output logic                                found_o,
  output logic [bst_pkg::ProbeW-1:0]          probe_count_o,
  output logic                                status_o
);
  import bst_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);
  localparam logic [ProbeW-1:0] ProbeMax = '1;

  logic [1:0]             func_q;
  logic signed [KeyW-1:0] key_q;
  logic signed [KeyW-1:0] rdata_q;
  logic signed [KeyW-1:0] mem_q [TABLE_DEPTH];
  logic [CW-1:0]          count_q;
  logic [CW-1:0]          lo_q;
  logic [CW-1:0]          hi1_q;   // one past the upper bound
  logic [CW-1:0]          mid_q;
  logic [CW-1:0]          span;
  logic [CW-1:0]          mid_d;
  logic [ProbeW-1:0]      probes_q;
  logic                   full;
  logic                   crossed;
  logic                   valid_q;
  logic                   found_q;
  logic [ProbeW-1:0]      probe_out_q;
  logic                   status_q;

  assign full    = (count_q == DepthC);
  assign crossed = (lo_q >= hi1_q);
  assign span    = hi1_q - lo_q - 1'b1;
  assign mid_d   = lo_q + (span >> 1);

  assign stat_o.is_append = (func_q == FUNC_APPEND);
  assign stat_o.is_clear  = (func_q == FUNC_CLEAR);
  assign stat_o.is_search = (func_q == FUNC_SEARCH);
  assign stat_o.crossed   = crossed;
  assign stat_o.miss      = (rdata_q != key_q);

  // key table: one write port for append, one registered read for probes
  always_ff @(posedge clk_i) begin
    if (ucode_i.op == OP_APPEND && !full) begin
      mem_q[count_q[AW-1:0]] <= key_q;
    end
    if (ucode_i.op == OP_PROBE) begin
      rdata_q <= mem_q[mid_d[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ucode_i.op == OP_LATCH && start) begin
      func_q <= func_i;
      key_q  <= key_value_i;
    end
    if (ucode_i.op == OP_PROBE) begin
      mid_q <= mid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      lo_q     <= '0;
      hi1_q    <= '0;
      probes_q <= '0;
    end else begin
      unique case (ucode_i.op)
        OP_APPEND: begin
          if (!full) count_q <= count_q + 1'b1;
        end
        OP_CLEAR: begin
          count_q <= '0;
        end
        OP_INIT: begin
          lo_q     <= '0;
          hi1_q    <= count_q;
          probes_q <= '0;
        end
        OP_COMPARE: begin
          if (probes_q != ProbeMax) probes_q <= probes_q + 1'b1;
          if (rdata_q != key_q) begin
            if (rdata_q < key_q) lo_q <= mid_q + 1'b1;
            else hi1_q <= mid_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result beat register, one cycle wide
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= (ucode_i.op == OP_ZERO) || (ucode_i.op == OP_APPEND) ||
                 (ucode_i.op == OP_CLEAR) || ucode_i.emit_search;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q     <= 1'b0;
    probe_out_q <= '0;
    status_q    <= 1'b0;
    if (ucode_i.op == OP_APPEND) begin
      status_q <= full;
    end
    if (ucode_i.emit_search) begin
      // a hit leaves the bounds uncrossed
      found_q     <= !crossed;
      probe_out_q <= probes_q;
    end
  end

  assign result_valid_o = valid_q;
  assign found_o        = found_q;
  assign probe_count_o  = probe_out_q;
  assign status_o       = status_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("entry count beyond table depth");

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ucode_i.op == OP_COMPARE) |-> (mid_q < count_q))
    else $error("probe outside filled entries");

  a_found_has_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && found_q) |-> (probe_out_q != '0))
    else $error("hit reported without a probe");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ucode_i.op == OP_APPEND && !full) |=> (count_q == $past(count_q) + 1'b1))
    else $error("append did not grow the table");

endmodule

`default_nettype wire

// ===== hdl/binary_search_table_top.sv =====
// channel  | direction | ports                                   | handshake
// ---------+-----------+-----------------------------------------+----------------------
// command  | in        | func_i, key_value_i                     | start high, busy low
// result   | out       | found_o, probe_count_o, status_o        | result_valid_o pulse
//
// one command at a time; a microcode step counter runs each command.
// decode steps test the code; append, clear and unused-code steps emit the beat;
// a search: an init step, then per probe a registered read and a compare step,
// up to log2(TABLE_DEPTH) + 1 probes, then a done step that emits the beat; the
// next command can go in on the edge that takes the result beat.
// reset clears the entry count and the step counter; table contents stay.
// the result beat lasts one cycle and cannot be stalled.
`default_nettype none

module binary_search_table_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [1:0]                      func_i,
  input  wire logic signed [bst_pkg::KeyW-1:0] key_value_i,
  output logic                                 result_valid_o,
  output logic                                 found_o,
  output logic [bst_pkg::ProbeW-1:0]           probe_count_o,
  output logic                                 status_o
);
  import bst_pkg::*;

  ucode_t   ucode;
  dp_stat_t stat;

  bst_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .stat_i  (stat),
    .ucode_o (ucode),
    .busy_o  (busy)
  );

  bst_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .ucode_i        (ucode),
    .func_i         (func_i),
    .key_value_i    (key_value_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .found_o        (found_o),
    .probe_count_o  (probe_count_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bst_pkg::*;

  localparam int unsigned TableDepth  = 32;
  localparam int unsigned ItemTarget  = 800;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 30;

  typedef struct {
    logic              found;
    logic [ProbeW-1:0] probes;
    logic              status;
  } lookup_result_t;

  class key_table_sb;
    logic signed [KeyW-1:0] keys [TableDepth];
    int unsigned            fill = 0;
    lookup_result_t         pending [$];
    int unsigned            errors = 0;
    int unsigned            appends = 0, drops = 0, clears = 0;
    int unsigned            hits = 0, misses = 0, unused = 0;

    // predict the result beat for an accepted command
    function void note_command(func_e f, logic signed [KeyW-1:0] k);
      lookup_result_t r;
      int lo, hi, mid;
      r = '{found: 1'b0, probes: '0, status: 1'b0};
      case (f)
        FUNC_APPEND: begin
          appends++;
          if (fill >= TableDepth) begin
            r.status = 1'b1;
            drops++;
          end else begin
            keys[fill] = k;
            fill++;
          end
        end
        FUNC_CLEAR: begin
          fill = 0;
          clears++;
        end
        FUNC_SEARCH: begin
          lo = 0;
          hi = int'(fill) - 1;
          // same probe order as the block, sorted or not
          while (lo <= hi && !r.found) begin
            mid = lo + (hi - lo) / 2;
            if (r.probes != '1) r.probes++;
            if (keys[mid] == k) r.found = 1'b1;
            else if (keys[mid] < k) lo = mid + 1;
            else hi = mid - 1;
          end
          if (r.found) hits++;
          else misses++;
        end
        default: unused++;
      endcase
      pending = {pending, r};
    endfunction

    function void check_result(logic found, logic [ProbeW-1:0] probes, logic status);
      lookup_result_t want;
      if (pending.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      if (found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, found);
        errors++;
      end
      if (probes !== want.probes) begin
        $error("probe_count: expected %0d, got %0d", want.probes, probes);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             func_i = '0;
  logic signed [KeyW-1:0] key_value_i = '0;
  logic                   result_valid_o;
  logic                   found_o;
  logic [ProbeW-1:0]      probe_count_o;
  logic                   status_o;

  key_table_sb sb;
  bit          gaps_on = 1'b1;
  int unsigned sent = 0;
  int unsigned stall_cycles = 0;

  binary_search_table_top #(
    .TABLE_DEPTH(TableDepth)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .key_value_i   (key_value_i),
    .result_valid_o(result_valid_o),
    .found_o       (found_o),
    .probe_count_o (probe_count_o),
    .status_o      (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result monitor and stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(found_o, probe_count_o, status_o);
      if ((start && !busy) || result_valid_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_cmd(input func_e f, input logic signed [KeyW-1:0] k);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    func_i      <= f;
    key_value_i <= k;
    do @(posedge clk_i); while (busy);
    sb.note_command(f, k);
    if (f != FUNC_NONE) sent++;
  endtask

  // hold off until every beat in flight has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // mostly: clear, load a sorted table, then search it
  task automatic run_table_sequence();
    shortint     fill_keys [TableDepth + 4];
    shortint     tmp;
    logic signed [KeyW-1:0] probe_key;
    int unsigned n, n_search, loaded, r;
    bit          ordered, narrow;
    func_e       f;
    gaps_on = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 7) != 0) send_cmd(FUNC_CLEAR, KeyW'($urandom));
    case ($urandom_range(0, 5))
      0:       n = TableDepth + $urandom_range(0, 4);
      1:       n = $urandom_range(0, 3);
      default: n = $urandom_range(0, TableDepth);
    endcase
    ordered = ($urandom_range(0, 7) != 0);
    narrow  = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      if (narrow) fill_keys[i] = shortint'(int'($urandom_range(0, 15)) - 8);
      else fill_keys[i] = shortint'($urandom);
    end
    if (ordered) begin
      for (int i = 1; i < n; i++) begin
        tmp = fill_keys[i];
        for (int j = i; j > 0 && fill_keys[j-1] > tmp; j--) begin
          fill_keys[j]   = fill_keys[j-1];
          fill_keys[j-1] = tmp;
        end
      end
    end
    for (int i = 0; i < n; i++) send_cmd(FUNC_APPEND, fill_keys[i]);
    loaded   = (n > TableDepth) ? TableDepth : n;
    n_search = $urandom_range(2, 12);
    for (int i = 0; i < n_search; i++) begin
      r = $urandom_range(0, 9);
      f = FUNC_SEARCH;
      probe_key = KeyW'($urandom);
      if (loaded > 0 && r < 5) begin
        probe_key = fill_keys[$urandom_range(0, loaded - 1)];
      end else if (loaded > 0 && r < 7) begin
        probe_key = fill_keys[$urandom_range(0, loaded - 1)];
        probe_key = $urandom_range(0, 1) ? probe_key + 16'sd1 : probe_key - 16'sd1;
      end else if (r == 9) begin
        f = FUNC_NONE;
      end
      send_cmd(f, probe_key);
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, single entry, unused code, extremes, misses, clear, unsorted
    send_cmd(FUNC_SEARCH, 16'sd100);
    send_cmd(FUNC_APPEND, -16'sd32768);
    send_cmd(FUNC_SEARCH, -16'sd32768);
    send_cmd(FUNC_SEARCH, 16'sd0);
    send_cmd(FUNC_NONE, -16'sd1);
    send_cmd(FUNC_APPEND, -16'sd1);
    send_cmd(FUNC_APPEND, 16'sd0);
    send_cmd(FUNC_APPEND, 16'sd1);
    send_cmd(FUNC_APPEND, 16'sd32767);
    send_cmd(FUNC_SEARCH, 16'sd32767);
    send_cmd(FUNC_SEARCH, -16'sd32768);
    send_cmd(FUNC_SEARCH, 16'sd0);
    send_cmd(FUNC_SEARCH, 16'sd2);
    send_cmd(FUNC_SEARCH, -16'sd2);
    send_cmd(FUNC_CLEAR, 16'sd0);
    send_cmd(FUNC_SEARCH, 16'sd0);
    send_cmd(FUNC_APPEND, 16'sd5);
    send_cmd(FUNC_APPEND, 16'sd3);
    send_cmd(FUNC_APPEND, 16'sd9);
    send_cmd(FUNC_SEARCH, 16'sd3);
    send_cmd(FUNC_SEARCH, 16'sd9);
    send_cmd(FUNC_CLEAR, -16'sd1);
    wait_drained();

    while (sent < ItemTarget) begin
      run_table_sequence();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d appends (%0d dropped on a full table), %0d clears,",
             sb.appends, sb.drops, sb.clears);
    $display("%0d searches (%0d hits, %0d misses) and %0d unused-code beats",
             sb.hits + sb.misses, sb.hits, sb.misses, sb.unused);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
